>>> hw/rtl/gcs_pkg.sv
// shared types and constants for the grouped column statistics block
// no dependencies
`default_nettype none
package gcs_pkg;

  localparam int VALUE_BITS_DEF     = 16;
  localparam int MAX_GROUP_ROWS_DEF = 16777216;
  localparam int FRACTION_BITS_DEF  = 16;

  localparam int ALU_W = 80;   // widest operand: n times sum of squares
  localparam int DVD_W = 112;  // numerator shifted by two fraction widths
  localparam int CNT_W = 7;    // step counter, longest run is 112 steps

  // running group totals handed from the accumulator to the calculator
  typedef struct packed {
    logic [24:0]        count;
    logic signed [39:0] sum;
    logic [54:0]        sq_sum;
    logic signed [15:0] vmin;
    logic signed [15:0] vmax;
    logic               ovf;
    logic [23:0]        gidx;
  } gcs_snap_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_NSS,
    ST_MUL_SS,
    ST_SUB_NUM,
    ST_MUL_DEN,
    ST_DIV_VAR,
    ST_SQRT,
    ST_DIV_MEAN,
    ST_NEG_MEAN,
    ST_DONE
  } calc_state_t;

endpackage
`default_nettype wire

>>> hw/rtl/gcs_alu.sv
// shared add/subtract unit with carry out
// depends on gcs_pkg
`default_nettype none
module gcs_alu
  import gcs_pkg::*;
(
  input  wire logic [ALU_W-1:0] a,
  input  wire logic [ALU_W-1:0] b,
  input  wire logic             sub,
  output logic      [ALU_W-1:0] sum,
  output logic                  carry
);

  logic [ALU_W-1:0] b_op;

  always_comb begin
    b_op = sub ? ~b : b;
    {carry, sum} = {1'b0, a} + {1'b0, b_op} + {{ALU_W{1'b0}}, sub};
  end

endmodule
`default_nettype wire

>>> hw/rtl/gcs_accum.sv
// per-row accumulation of count, sum, sum of squares, min and max
// depends on gcs_pkg
`default_nettype none
module gcs_accum
  import gcs_pkg::*;
#(
  parameter int VALUE_BITS     = VALUE_BITS_DEF,
  parameter int MAX_GROUP_ROWS = MAX_GROUP_ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [15:0] value,
  input  wire logic        missing,
  input  wire logic        last,
  input  wire logic        clear,
  output gcs_snap_t        snap,
  output logic             grp_done
);

  localparam int SH = 16 - VALUE_BITS;
  localparam logic signed [15:0] VMAX = 16'((1 << (VALUE_BITS - 1)) - 1);
  localparam logic signed [15:0] VMIN = -VMAX - 16'sd1;

  logic signed [15:0] v;
  logic        [31:0] sq;
  logic               full;

  always_comb begin
    v    = $signed(value << SH) >>> SH;
    sq   = 32'(v * v);
    full = snap.count >= 25'(MAX_GROUP_ROWS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap.count  <= '0;
      snap.sum    <= '0;
      snap.sq_sum <= '0;
      snap.vmin   <= VMAX;
      snap.vmax   <= VMIN;
      snap.ovf    <= 1'b0;
      snap.gidx   <= '0;
      grp_done    <= 1'b0;
    end else if (clear) begin
      snap.count  <= '0;
      snap.sum    <= '0;
      snap.sq_sum <= '0;
      snap.vmin   <= VMAX;
      snap.vmax   <= VMIN;
      snap.ovf    <= 1'b0;
      snap.gidx   <= snap.gidx + 24'd1;
      grp_done    <= 1'b0;
    end else if (accept) begin
      grp_done <= last;
      if (!missing) begin
        if (full) begin
          snap.ovf <= 1'b1;
        end else begin
          snap.count  <= snap.count + 25'd1;
          snap.sum    <= snap.sum + 40'(v);
          snap.sq_sum <= snap.sq_sum + 55'(sq);
          if (v < snap.vmin) snap.vmin <= v;
          if (v > snap.vmax) snap.vmax <= v;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/gcs_calc.sv
// group-end sequencer: shift-add multiply, restoring divide and digit square root
// on one shared add/subtract unit; holds the result register; depends on gcs_pkg, gcs_alu
`default_nettype none
module gcs_calc
  import gcs_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire gcs_snap_t    snap,
  output logic              idle,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [23:0]       o_gidx,
  output logic [24:0]       o_count,
  output logic [39:0]       o_total,
  output logic [15:0]       o_min,
  output logic [15:0]       o_max,
  output logic [31:0]       o_mean,
  output logic [31:0]       o_stdev,
  output logic              o_ext_valid,
  output logic              o_mean_valid,
  output logic              o_stdev_valid,
  output logic              o_ovf
);

  calc_state_t state, state_next;

  logic [24:0]        n;
  logic signed [39:0] s;
  logic [39:0]        smag, smag_in;
  logic signed [15:0] mn, mx;
  logic               ovf;
  logic [23:0]        gidx;

  logic [ALU_W-1:0] prod, mcand, p1, rem;
  logic [39:0]      mplier;
  logic [49:0]      den;
  logic [DVD_W-1:0] dvd;
  logic [63:0]      quo;
  logic [31:0]      root, stdev, mean;
  logic [CNT_W-1:0] cnt;
  logic             last_step;

  logic [ALU_W-1:0] alu_a, alu_b, alu_sum, rem_sh;
  logic             alu_sub, alu_carry;
  logic [ALU_W-1:0] mul_acc, rem_nx;
  logic [63:0]      quo_nx;
  logic [31:0]      root_nx;
  logic             out_free;

  gcs_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  assign idle      = state == ST_IDLE;
  assign last_step = cnt == CNT_W'(1);
  assign out_free  = !out_valid || out_ready;
  assign smag_in   = snap.sum[39] ? 40'(-snap.sum) : snap.sum;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (snap.count == 25'd0)      state_next = ST_DONE;
          else if (snap.count == 25'd1) state_next = ST_DIV_MEAN;
          else                          state_next = ST_MUL_NSS;
        end
      end
      ST_MUL_NSS:  if (last_step) state_next = ST_MUL_SS;
      ST_MUL_SS:   if (last_step) state_next = ST_SUB_NUM;
      ST_SUB_NUM:  state_next = ST_MUL_DEN;
      ST_MUL_DEN:  if (last_step) state_next = ST_DIV_VAR;
      ST_DIV_VAR:  if (last_step) state_next = ST_SQRT;
      ST_SQRT:     if (last_step) state_next = ST_DIV_MEAN;
      ST_DIV_MEAN: if (last_step) state_next = ST_NEG_MEAN;
      ST_NEG_MEAN: state_next = ST_DONE;
      ST_DONE:     if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // shared unit operands
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    rem_sh  = {rem[ALU_W-2:0], dvd[DVD_W-1]};
    case (state)
      ST_MUL_NSS, ST_MUL_SS, ST_MUL_DEN: begin
        alu_a = prod;
        alu_b = mcand;
      end
      ST_SUB_NUM: begin
        alu_a   = p1;
        alu_b   = prod;
        alu_sub = 1'b1;
      end
      ST_DIV_VAR, ST_DIV_MEAN: begin
        alu_a   = rem_sh;
        alu_b   = ALU_W'(den);
        alu_sub = 1'b1;
      end
      ST_SQRT: begin
        rem_sh  = {rem[ALU_W-3:0], dvd[DVD_W-1 -: 2]};
        alu_a   = rem_sh;
        alu_b   = ALU_W'({root, 2'b01});
        alu_sub = 1'b1;
      end
      ST_NEG_MEAN: begin
        alu_b   = ALU_W'(quo);
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
    mul_acc = mplier[0] ? alu_sum : prod;
    rem_nx  = alu_carry ? alu_sum : rem_sh;
    quo_nx  = {quo[62:0], alu_carry};
    root_nx = {root[30:0], alu_carry};
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          n      <= snap.count;
          s      <= snap.sum;
          smag   <= smag_in;
          mn     <= snap.vmin;
          mx     <= snap.vmax;
          ovf    <= snap.ovf;
          gidx   <= snap.gidx;
          mean   <= '0;
          stdev  <= '0;
          prod   <= '0;
          mcand  <= ALU_W'(snap.sq_sum);
          mplier <= 40'(snap.count);
          cnt    <= CNT_W'(25);
          // single value: straight to the mean divide
          dvd    <= {smag_in, 72'b0};
          rem    <= '0;
          quo    <= '0;
          den    <= 50'(snap.count);
          if (snap.count == 25'd1) cnt <= CNT_W'(40 + FRACTION_BITS);
        end
      end
      ST_MUL_NSS, ST_MUL_SS, ST_MUL_DEN: begin
        prod   <= mul_acc;
        mcand  <= {mcand[ALU_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[39:1]};
        cnt    <= cnt - CNT_W'(1);
        if (last_step) begin
          case (state)
            ST_MUL_NSS: begin
              p1     <= mul_acc;
              prod   <= '0;
              mcand  <= ALU_W'(smag);
              mplier <= smag;
              cnt    <= CNT_W'(40);
            end
            ST_MUL_DEN: begin
              den <= mul_acc[49:0];
              dvd <= {p1, 32'b0};
              rem <= '0;
              quo <= '0;
              cnt <= CNT_W'(80 + 2 * FRACTION_BITS);
            end
            default: begin
              prod <= mul_acc;
            end
          endcase
        end
      end
      ST_SUB_NUM: begin
        p1     <= alu_sum;
        prod   <= '0;
        mcand  <= ALU_W'(n);
        mplier <= 40'(n - 25'd1);
        cnt    <= CNT_W'(25);
      end
      ST_DIV_VAR, ST_DIV_MEAN: begin
        rem <= rem_nx;
        quo <= quo_nx;
        dvd <= {dvd[DVD_W-2:0], 1'b0};
        cnt <= cnt - CNT_W'(1);
        if (last_step && state == ST_DIV_VAR) begin
          dvd  <= {quo_nx, 48'b0};
          rem  <= '0;
          root <= '0;
          cnt  <= CNT_W'(32);
        end
      end
      ST_SQRT: begin
        rem  <= rem_nx;
        root <= root_nx;
        dvd  <= {dvd[DVD_W-3:0], 2'b00};
        cnt  <= cnt - CNT_W'(1);
        if (last_step) begin
          stdev <= root_nx;
          dvd   <= {smag, 72'b0};
          rem   <= '0;
          quo   <= '0;
          den   <= 50'(n);
          cnt   <= CNT_W'(40 + FRACTION_BITS);
        end
      end
      ST_NEG_MEAN: begin
        mean <= s[39] ? alu_sum[31:0] : quo[31:0];
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      o_gidx        <= gidx;
      o_count       <= n;
      o_total       <= s;
      o_min         <= (n != 25'd0) ? mn : 16'd0;
      o_max         <= (n != 25'd0) ? mx : 16'd0;
      o_ext_valid   <= n != 25'd0;
      o_mean        <= mean;
      o_mean_valid  <= n != 25'd0;
      o_stdev       <= stdev;
      o_stdev_valid <= n >= 25'd2;
      o_ovf         <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (out_ready)               out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/grouped_column_statistics.sv
// top level of the grouped column statistics block
// depends on gcs_pkg, gcs_accum, gcs_calc (and gcs_alu below it)
//
// channel  dir  payload
// s_axis   in   tdata[15:0] value; tuser[0] is_missing; tlast last_in_group
// m_axis   out  one result request per group end, fields listed at the ports
//
// rows are taken one per cycle while the calculator is idle and no group end is pending
// a group end holds tready low while the shared add/subtract unit works: for n >= 2
// three shift-add multiplies, two restoring divides and a 32-step square root,
// for n = 1 the mean divide only, for n = 0 none of them
// the result sits in an output register, rows of the next group flow while it waits
// a group end that finds the result register still full waits for it to drain
// rst is synchronous, active high, and clears all running totals
`default_nettype none
module grouped_column_statistics
  import gcs_pkg::*;
#(
  parameter int VALUE_BITS     = VALUE_BITS_DEF,
  parameter int MAX_GROUP_ROWS = MAX_GROUP_ROWS_DEF,
  parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [15:0]  s_axis_tdata,   // [15:0] value
  input  wire logic [0:0]   s_axis_tuser,   // [0] is_missing
  input  wire logic         s_axis_tlast,   // last_in_group
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [23:0] group_index, [48:24] valid_count, [88:49] total, [104:89] smallest,
  // [120:105] largest, [152:121] mean_q16, [184:153] stdev_q16, rest zero
  output logic [191:0]      m_axis_tdata,
  // [0] extremes_valid, [1] mean_valid, [2] stdev_valid, [3] count_overflow
  output logic [3:0]        m_axis_tuser
);

  gcs_snap_t snap;
  logic      grp_done;
  logic      calc_idle;
  logic      accept;
  logic      start;

  logic [23:0] o_gidx;
  logic [24:0] o_count;
  logic [39:0] o_total;
  logic [15:0] o_min, o_max;
  logic [31:0] o_mean, o_stdev;
  logic        o_ext_valid, o_mean_valid, o_stdev_valid, o_ovf;

  // closed group is handed over in the cycle after its last row
  assign s_axis_tready = calc_idle && !grp_done;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign start         = grp_done && calc_idle;

  gcs_accum #(
    .VALUE_BITS     (VALUE_BITS),
    .MAX_GROUP_ROWS (MAX_GROUP_ROWS)
  ) u_accum (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .value    (s_axis_tdata),
    .missing  (s_axis_tuser[0]),
    .last     (s_axis_tlast),
    .clear    (start),
    .snap     (snap),
    .grp_done (grp_done)
  );

  gcs_calc #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_calc (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .snap          (snap),
    .idle          (calc_idle),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .o_gidx        (o_gidx),
    .o_count       (o_count),
    .o_total       (o_total),
    .o_min         (o_min),
    .o_max         (o_max),
    .o_mean        (o_mean),
    .o_stdev       (o_stdev),
    .o_ext_valid   (o_ext_valid),
    .o_mean_valid  (o_mean_valid),
    .o_stdev_valid (o_stdev_valid),
    .o_ovf         (o_ovf)
  );

  assign m_axis_tdata = {7'b0, o_stdev, o_mean, o_max, o_min, o_total, o_count, o_gidx};
  assign m_axis_tuser = {o_ovf, o_stdev_valid, o_mean_valid, o_ext_valid};

endmodule
`default_nettype wire

>>> test/gcs_checker.sv
// checker for grouped_column_statistics: watches both stream channels,
// predicts each group result from the accepted rows and compares them field by field
// depends on the block's port layout only
module gcs_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,
  input  logic [0:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [191:0] m_axis_tdata,
  input  logic [3:0]   m_axis_tuser,
  output int           errors,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [23:0]        gidx;
    logic [24:0]        cnt;
    logic signed [39:0] total;
    logic signed [15:0] smallest;
    logic signed [15:0] largest;
    logic               ext_ok;
    logic [31:0]        mean;
    logic               mean_ok;
    logic [31:0]        stdev;
    logic               stdev_ok;
    logic               ovf;
  } group_stats_t;

  localparam longint ROW_LIMIT = 64'd16777216;

  group_stats_t stats_q[$];

  // own copy of the group accumulators
  logic [24:0]        acc_cnt;
  logic signed [39:0] acc_sum;
  logic [54:0]        acc_sq;
  logic signed [15:0] acc_min, acc_max;
  logic               acc_ovf;
  logic [23:0]        acc_gidx;

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  task automatic clear_group();
    acc_cnt = 0;
    acc_sum = 0;
    acc_sq  = 0;
    acc_min = 16'sh7fff;
    acc_max = -16'sh8000;
    acc_ovf = 0;
  endtask

  task automatic take_row(input logic signed [15:0] v, input logic miss, input logic last);
    group_stats_t r;
    logic [63:0]  smag, q;
    logic [127:0] num, den;
    logic [31:0]  mag;
    if (!miss) begin
      if (acc_cnt >= ROW_LIMIT) begin
        acc_ovf = 1;
      end else begin
        mag = (v < 0) ? -32'(v) : 32'(v);
        acc_cnt = acc_cnt + 1;
        acc_sum = acc_sum + v;
        acc_sq  = acc_sq + 55'(mag * mag);
        if (v < acc_min) acc_min = v;
        if (v > acc_max) acc_max = v;
      end
    end
    if (!last) return;
    r = '0;
    r.gidx  = acc_gidx;
    r.cnt   = acc_cnt;
    r.total = acc_sum;
    r.ovf   = acc_ovf;
    smag = (acc_sum < 0) ? 64'(-acc_sum) : 64'(acc_sum);
    if (acc_cnt >= 1) begin
      r.ext_ok   = 1;
      r.mean_ok  = 1;
      r.smallest = acc_min;
      r.largest  = acc_max;
      q = (smag << 16) / 64'(acc_cnt);
      r.mean = (acc_sum < 0) ? 32'(64'd0 - q) : q[31:0];
    end
    if (acc_cnt >= 2) begin
      r.stdev_ok = 1;
      // exact variance numerator, scaled by two fraction widths before the divide
      num = 128'(acc_cnt) * 128'(acc_sq) - 128'(smag) * 128'(smag);
      num = num << 32;
      den = 128'(acc_cnt) * 128'(acc_cnt - 25'd1);
      q = 64'(num / den);
      r.stdev = 32'(int_sqrt(q));
    end
    stats_q.push_back(r);
    acc_gidx = acc_gidx + 1;
    clear_group();
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    group_stats_t e;
    if (rst) begin
      clear_group();
      acc_gidx = 0;
      stats_q.delete();
      errors = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        take_row(s_axis_tdata, s_axis_tuser[0], s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (stats_q.size() == 0) begin
          $error("result with no group pending");
          errors++;
        end else begin
          e = stats_q.pop_front();
          check_field("group_index", e.gidx, m_axis_tdata[23:0]);
          check_field("valid_count", e.cnt, m_axis_tdata[48:24]);
          check_field("total", $unsigned(e.total), m_axis_tdata[88:49]);
          check_field("smallest", $unsigned(e.smallest), m_axis_tdata[104:89]);
          check_field("largest", $unsigned(e.largest), m_axis_tdata[120:105]);
          check_field("mean_q16", e.mean, m_axis_tdata[152:121]);
          check_field("stdev_q16", e.stdev, m_axis_tdata[184:153]);
          check_field("extremes_valid", e.ext_ok, m_axis_tuser[0]);
          check_field("mean_valid", e.mean_ok, m_axis_tuser[1]);
          check_field("stdev_valid", e.stdev_ok, m_axis_tuser[2]);
          check_field("count_overflow", e.ovf, m_axis_tuser[3]);
        end
      end
    end
    pending = stats_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end
endmodule

>>> test/tb_grouped_column_statistics.sv
// testbench top for grouped_column_statistics: drives rows, idles both sides,
// gives the verdict; prediction and comparison live in gcs_checker
// depends on gcs_pkg, grouped_column_statistics, gcs_checker
module tb_grouped_column_statistics;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 3000000;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         s_axis_tlast = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [191:0] m_axis_tdata;
  logic [3:0]   m_axis_tuser;

  int     errors, pending;
  int     tx_idle_pct = 9;   // sender gap odds per cycle, percent
  int     rx_idle_pct = 60;  // receiver stall odds, percent
  int     hold_asks = 0;     // bumped to ask the receiver for a long hold-off
  int     holds_done = 0;
  int     hold_left = 0;
  longint cycles = 0;
  int     rows_sent = 0;

  always #10 clk = ~clk;

  grouped_column_statistics dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  gcs_checker chk (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .errors, .pending
  );

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on request so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 0;
    end else if (holds_done != hold_asks) begin
      holds_done++;
      hold_left = 1500;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // offer one row and wait for its handshake; idle cycles drawn one at a time in front
  task automatic send_row(input logic [15:0] v, input logic miss, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= miss;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    rows_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_value();
    case ($urandom_range(5))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 20)) - 16'd10;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int glen, budget;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty group, all-missing group, one value each extreme,
    // identical values (zero spread), wide spread, negative mean rounding
    send_row(16'h0000, 1, 1);
    send_row(16'h1234, 1, 0); send_row(16'h4321, 1, 1);
    send_row(16'h7fff, 0, 1);
    send_row(16'h8000, 0, 1);
    send_row(16'h7fff, 0, 0); send_row(16'h7fff, 0, 0); send_row(16'h7fff, 0, 1);
    send_row(16'h8000, 0, 0); send_row(16'h7fff, 1, 0); send_row(16'h7fff, 0, 1);
    send_row(16'hffff, 0, 0); send_row(16'h0000, 0, 0); send_row(16'h0000, 0, 1);
    send_row(16'h8000, 0, 0); send_row(16'h8000, 0, 0); send_row(16'h8000, 0, 0);
    send_row(16'h8000, 0, 1);
    send_row(16'h0001, 0, 0); send_row(16'h0002, 0, 0); send_row(16'h5555, 0, 0);
    send_row(16'haaaa, 1, 1);

    // sender pauses until every expected result is out
    wait_drained();

    budget = 1050;
    while (rows_sent < budget) begin
      if (rows_sent > 370 && tx_idle_pct == 9) begin
        tx_idle_pct = 60;
        rx_idle_pct = 9;
      end else if (rows_sent > 720 && tx_idle_pct == 60) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (rows_sent > 150 && hold_asks == 0) hold_asks = 1;
      glen = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int i = 0; i < glen; i++)
        send_row(rand_value(), $urandom_range(9) == 0, i == glen - 1);
    end

    wait_drained();
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

>>> files.f
hw/rtl/gcs_pkg.sv
hw/rtl/gcs_alu.sv
hw/rtl/gcs_accum.sv
hw/rtl/gcs_calc.sv
hw/rtl/grouped_column_statistics.sv
test/gcs_checker.sv
test/tb_grouped_column_statistics.sv
